>>> sv/cbb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the cascaded ball balance controller.
package cbb_pkg;

    // Multiplier operand and product widths
    localparam int MUL_AW = 20;
    localparam int MUL_BW = 17;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int MUL_CW = 5;

    localparam logic signed [7:0] TARGET_MIN = -8'sd125;
    localparam logic signed [7:0] TARGET_MAX = 8'sd125;
    localparam logic [8:0] SMOOTH_ONE = 9'd256;

    typedef enum logic [1:0] {
        FN_OUTER = 2'd0,
        FN_INNER = 2'd1,
        FN_STOP  = 2'd2,
        FN_ZERO  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_TARGET   = 3'd0,
        REG_KP       = 3'd1,
        REG_KD       = 3'd2,
        REG_LIMIT    = 3'd3,
        REG_KI       = 3'd4,
        REG_KFF      = 3'd5,
        REG_SMOOTH   = 3'd6,
        REG_TOL      = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILT,
        ST_POS,
        ST_VEL,
        ST_FF,
        ST_INNER,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                     start;
        logic signed [MUL_AW-1:0] a;
        logic signed [MUL_BW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

>>> sv/cbb_mul.sv
`timescale 1ns / 1ps
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module cbb_mul
    import cbb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mul_req_t                 req,
    output mul_stat_t                stat,
    output logic signed [MUL_PW-1:0] prod
);

    logic signed [MUL_AW-1:0] a_reg;
    logic        [MUL_PW-1:0] p_reg;
    logic        [MUL_PW-1:0] p_next;
    logic        [MUL_CW-1:0] cnt_reg;
    logic                     done_reg;
    logic        [MUL_AW:0]   upper_ext;
    logic        [MUL_AW:0]   a_ext;
    logic        [MUL_AW:0]   sum;

    always_comb
    begin
        upper_ext = {p_reg[MUL_PW-1], p_reg[MUL_PW-1:MUL_BW]};
        a_ext     = {a_reg[MUL_AW-1], a_reg};
        if (!p_reg[0])
        begin
            sum = upper_ext;
        end
        else if (cnt_reg == MUL_CW'(1))
        begin
            // sign bit of the multiplier weighs negative
            sum = upper_ext - a_ext;
        end
        else
        begin
            sum = upper_ext + a_ext;
        end
        p_next = {sum, p_reg[MUL_BW-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= MUL_CW'(MUL_BW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - MUL_CW'(1);
            done_reg <= (cnt_reg == MUL_CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            p_reg <= {{MUL_AW{1'b0}}, req.b};
        end
        else if (cnt_reg != '0)
        begin
            p_reg <= p_next;
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign prod      = signed'(p_reg);

endmodule

>>> sv/cascaded_ball_balance_controller_top.sv
`timescale 1ns / 1ps
// Stop, capture zero and an inner tick with the motor off go to the output with no multiply.
// An outer tick runs up to four multiplies, an inner tick with the motor on just one.
// Each multiply runs bit-serially through one shared 17-step shift-add unit.
// One item at a time; the next item is taken while a finished result waits at the output.
// Reset (asynchronous, active low) loads register defaults and clears loop state but acc_reg.
module cascaded_ball_balance_controller_top
    import cbb_pkg::*;
#(
    parameter int DUTY_MAX   = 1600,
    parameter int ANGLE_BITS = 14
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [12:0] ball_position,
    input  logic signed [15:0] ball_velocity,
    input  logic               ball_seen,
    input  logic signed [15:0] carriage_accel,
    input  logic [13:0]        encoder_angle,
    input  logic               index_seen,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [10:0]        pwm_duty,
    output logic               direction,
    output logic               motor_enable,
    output logic signed [13:0] angle_setpoint,
    output logic signed [13:0] crank_angle,
    output logic               at_target
);

    localparam logic signed [37:0] DUTY_LIM = 38'(DUTY_MAX * 256);

    // configuration
    logic [7:0]  target_reg;
    logic [15:0] kp_reg;
    logic [15:0] kd_reg;
    logic [12:0] lim_reg;
    logic [15:0] ki_reg;
    logic [15:0] kff_reg;
    logic [8:0]  smooth_reg;
    logic [7:0]  tol_reg;

    // captured beat
    func_t              func_reg;
    logic signed [12:0] pos_reg;
    logic signed [15:0] vel_reg;
    logic               seen_reg;
    logic signed [15:0] accel_reg;
    logic [13:0]        enc_reg;
    logic               index_reg;

    // loop state
    state_t                   state_reg;
    state_t                   state_next;
    logic                     started_reg;
    logic                     primed_reg;
    logic                     motor_on_reg;
    logic signed [19:0]       filt_reg;
    logic signed [13:0]       setpoint_reg;
    logic signed [16:0]       ff_reg;
    logic [ANGLE_BITS-1:0]    zero_reg;
    logic [ANGLE_BITS-1:0]    wrapped_reg;
    logic [10:0]              held_duty_reg;
    logic                     held_dir_reg;
    logic signed [MUL_PW-1:0] acc_reg;

    logic               out_valid_reg;
    logic [10:0]        pwm_duty_reg;
    logic               direction_reg;
    logic               motor_enable_reg;
    logic signed [13:0] angle_setpoint_reg;
    logic signed [13:0] crank_angle_reg;
    logic               at_target_reg;

    mul_req_t                 mul_req;
    mul_stat_t                mul_stat;
    logic signed [MUL_PW-1:0] prod;

    logic                     in_fire;
    logic                     out_load;
    logic signed [7:0]        t_raw;
    logic signed [7:0]        t_sat;
    logic signed [19:0]       tq8;
    logic signed [19:0]       err;
    logic signed [19:0]       pos16;
    logic signed [19:0]       fdiff;
    logic [8:0]               smooth_sat;
    logic signed [37:0]       cmd_full;
    logic signed [21:0]       cmd_q;
    logic signed [21:0]       lim_x;
    logic signed [13:0]       cmd_clamp;
    logic signed [28:0]       ff_q;
    logic signed [16:0]       ff_sat;
    logic signed [37:0]       v_full;
    logic signed [37:0]       v_clamp;
    logic [37:0]              v_mag;
    logic [ANGLE_BITS-1:0]    enc_w;
    logic signed [ANGLE_BITS-1:0] wr_s;
    logic signed [19:0]       wrapped_x;
    logic signed [19:0]       idiff;
    logic [20:0]              e_abs;

    cbb_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .stat  (mul_stat),
        .prod  (prod)
    );

    // ---------------- datapath combinational ----------------
    always_comb
    begin
        t_raw = signed'(target_reg);
        if (t_raw < TARGET_MIN)
        begin
            t_sat = TARGET_MIN;
        end
        else if (t_raw > TARGET_MAX)
        begin
            t_sat = TARGET_MAX;
        end
        else
        begin
            t_sat = t_raw;
        end
        tq8        = {{4{t_sat[7]}}, t_sat, 8'b0};
        err        = tq8 - filt_reg;
        pos16      = {{3{pos_reg[12]}}, pos_reg, 4'b0};
        fdiff      = pos16 - filt_reg;
        smooth_sat = (smooth_reg > SMOOTH_ONE) ? SMOOTH_ONE : smooth_reg;

        cmd_full = {acc_reg[MUL_PW-1], acc_reg} - {prod[MUL_PW-1], prod};
        cmd_q    = cmd_full[37:16];
        lim_x    = {9'b0, lim_reg};
        if (cmd_q > lim_x)
        begin
            cmd_clamp = lim_x[13:0];
        end
        else if (cmd_q < -lim_x)
        begin
            cmd_clamp = 14'(-lim_x);
        end
        else
        begin
            cmd_clamp = cmd_q[13:0];
        end

        ff_q = prod[36:8];
        if (ff_q > 29'sd65535)
        begin
            ff_sat = 17'sd65535;
        end
        else if (ff_q < -29'sd65536)
        begin
            ff_sat = -17'sd65536;
        end
        else
        begin
            ff_sat = ff_q[16:0];
        end

        v_full = {prod[MUL_PW-1], prod} + {{13{ff_reg[16]}}, ff_reg, 8'b0};
        if (v_full > DUTY_LIM)
        begin
            v_clamp = DUTY_LIM;
        end
        else if (v_full < -DUTY_LIM)
        begin
            v_clamp = -DUTY_LIM;
        end
        else
        begin
            v_clamp = v_full;
        end
        v_mag = v_clamp[37] ? unsigned'(-v_clamp) : unsigned'(v_clamp);

        enc_w     = ANGLE_BITS'(enc_reg);
        wr_s      = signed'(wrapped_reg);
        wrapped_x = 20'(wr_s);
        idiff     = {{6{setpoint_reg[13]}}, setpoint_reg} - wrapped_x;

        e_abs = err[19] ? unsigned'(21'(-{err[19], err})) : unsigned'({1'b0, err});
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (func_reg)
                    FN_OUTER:
                    begin
                        if (primed_reg)
                        begin
                            state_next = ST_FILT;
                        end
                        else if (seen_reg)
                        begin
                            state_next = ST_POS;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    FN_INNER:
                    begin
                        state_next = motor_on_reg ? ST_INNER : ST_OUT;
                    end
                    FN_STOP, FN_ZERO:
                    begin
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_FILT:
            begin
                if (mul_stat.done)
                begin
                    state_next = seen_reg ? ST_POS : ST_OUT;
                end
            end
            ST_POS:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_VEL;
                end
            end
            ST_VEL:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_FF;
                end
            end
            ST_FF, ST_INNER:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        out_load      = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (state_reg)
            ST_FILT:
            begin
                mul_req.a = fdiff;
                mul_req.b = {8'b0, smooth_sat};
            end
            ST_POS:
            begin
                mul_req.a = err;
                mul_req.b = {1'b0, kp_reg};
            end
            ST_VEL:
            begin
                mul_req.a = {vel_reg, 4'b0};
                mul_req.b = {1'b0, kd_reg};
            end
            ST_FF:
            begin
                mul_req.a = {{4{accel_reg[15]}}, accel_reg};
                mul_req.b = {kff_reg[15], kff_reg};
            end
            ST_INNER:
            begin
                mul_req.a = idiff;
                mul_req.b = {1'b0, ki_reg};
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
        if ((state_reg == ST_FILT || state_reg == ST_POS || state_reg == ST_VEL
             || state_reg == ST_FF || state_reg == ST_INNER) && !started_reg)
        begin
            mul_req.start = 1'b1;
        end
    end

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mul_stat.done)
            begin
                started_reg <= 1'b0;
            end
            else if (mul_req.start)
            begin
                started_reg <= 1'b1;
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 8'd0;
            kp_reg     <= 16'd256;
            kd_reg     <= 16'd64;
            lim_reg    <= 13'd1024;
            ki_reg     <= 16'd256;
            kff_reg    <= 16'd0;
            smooth_reg <= 9'd256;
            tol_reg    <= 8'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TARGET: target_reg <= cfg_data[7:0];
                REG_KP:     kp_reg     <= cfg_data;
                REG_KD:     kd_reg     <= cfg_data;
                REG_LIMIT:  lim_reg    <= cfg_data[12:0];
                REG_KI:     ki_reg     <= cfg_data;
                REG_KFF:    kff_reg    <= cfg_data;
                REG_SMOOTH: smooth_reg <= cfg_data[8:0];
                REG_TOL:    tol_reg    <= cfg_data[7:0];
                default:    target_reg <= target_reg;
            endcase
        end
    end

    // capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg  <= func_t'(func);
            pos_reg   <= ball_position;
            vel_reg   <= ball_velocity;
            seen_reg  <= ball_seen;
            accel_reg <= carriage_accel;
            enc_reg   <= encoder_angle;
            index_reg <= index_seen;
        end
    end

    // loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            motor_on_reg  <= 1'b0;
            filt_reg      <= '0;
            setpoint_reg  <= '0;
            ff_reg        <= '0;
            zero_reg      <= '0;
            wrapped_reg   <= '0;
            held_duty_reg <= '0;
            held_dir_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_EXEC:
                begin
                    unique case (func_reg)
                        FN_OUTER:
                        begin
                            if (!primed_reg)
                            begin
                                // first sample goes in raw
                                filt_reg   <= pos16;
                                primed_reg <= 1'b1;
                                if (seen_reg)
                                begin
                                    motor_on_reg <= 1'b1;
                                end
                            end
                        end
                        FN_INNER:
                        begin
                            if (motor_on_reg)
                            begin
                                wrapped_reg <= enc_w - zero_reg;
                            end
                        end
                        FN_STOP:
                        begin
                            held_duty_reg <= '0;
                            held_dir_reg  <= 1'b0;
                            motor_on_reg  <= 1'b0;
                            ff_reg        <= '0;
                        end
                        FN_ZERO:
                        begin
                            zero_reg      <= enc_w;
                            primed_reg    <= 1'b0;
                            filt_reg      <= '0;
                            setpoint_reg  <= '0;
                            wrapped_reg   <= '0;
                            ff_reg        <= '0;
                            motor_on_reg  <= 1'b0;
                            held_duty_reg <= '0;
                            held_dir_reg  <= 1'b0;
                        end
                        default:
                        begin
                            motor_on_reg <= motor_on_reg;
                        end
                    endcase
                end
                ST_FILT:
                begin
                    if (mul_stat.done)
                    begin
                        filt_reg <= filt_reg + prod[27:8];
                        if (seen_reg)
                        begin
                            motor_on_reg <= 1'b1;
                        end
                    end
                end
                ST_VEL:
                begin
                    if (mul_stat.done)
                    begin
                        setpoint_reg <= cmd_clamp;
                    end
                end
                ST_FF:
                begin
                    if (mul_stat.done)
                    begin
                        ff_reg <= ff_sat;
                    end
                end
                ST_INNER:
                begin
                    if (mul_stat.done)
                    begin
                        held_dir_reg  <= !v_clamp[37];
                        held_duty_reg <= v_mag[18:8];
                        if (index_reg)
                        begin
                            zero_reg <= enc_w;
                        end
                    end
                end
                default:
                begin
                    motor_on_reg <= motor_on_reg;
                end
            endcase
        end
    end

    // hold the position product for the damping step
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_POS && mul_stat.done)
        begin
            acc_reg <= prod;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pwm_duty_reg       <= held_duty_reg;
            direction_reg      <= held_dir_reg;
            motor_enable_reg   <= motor_on_reg;
            angle_setpoint_reg <= setpoint_reg;
            crank_angle_reg    <= wrapped_x[13:0];
            at_target_reg      <= (e_abs <= {5'b0, tol_reg, 8'b0});
        end
    end

    assign out_valid      = out_valid_reg;
    assign pwm_duty       = pwm_duty_reg;
    assign direction      = direction_reg;
    assign motor_enable   = motor_enable_reg;
    assign angle_setpoint = angle_setpoint_reg;
    assign crank_angle    = crank_angle_reg;
    assign at_target      = at_target_reg;

`ifndef ASSERT_OFF
    a_start_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_stat.busy)
        else $error("multiply started while the unit is busy");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_EXEC)
        else $error("accepted beat not executed next cycle");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && func_reg == FN_STOP)
        |=> (held_duty_reg == '0 && !motor_on_reg))
        else $error("stop left the motor running");

    a_setpoint_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FF && $past(state_reg) == ST_VEL)
        |-> (signed'({{8{setpoint_reg[13]}}, setpoint_reg}) <= lim_x
             && signed'({{8{setpoint_reg[13]}}, setpoint_reg}) >= -lim_x))
        else $error("crank setpoint outside its limit");
`endif

endmodule

>>> test/cascaded_ball_balance_controller_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the cascaded ball balance controller with its own loop predictor.
module cascaded_ball_balance_controller_top_test
    import cbb_pkg::*;
;

    localparam int DUTY_LIM = 1600;
    localparam int ABITS = 14;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [10:0] duty;
        logic        dir;
        logic        en;
        logic [13:0] setp;
        logic [13:0] crank;
        logic        at_tgt;
    } ctl_out_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [1:0] func;
    logic signed [12:0] ball_position;
    logic signed [15:0] ball_velocity;
    logic ball_seen;
    logic signed [15:0] carriage_accel;
    logic [13:0] encoder_angle;
    logic index_seen;
    logic out_valid;
    logic out_ready;
    logic [10:0] pwm_duty;
    logic direction;
    logic motor_enable;
    logic signed [13:0] angle_setpoint;
    logic signed [13:0] crank_angle;
    logic at_target;

    cascaded_ball_balance_controller_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .ball_position(ball_position), .ball_velocity(ball_velocity),
        .ball_seen(ball_seen), .carriage_accel(carriage_accel),
        .encoder_angle(encoder_angle), .index_seen(index_seen),
        .out_valid(out_valid), .out_ready(out_ready),
        .pwm_duty(pwm_duty), .direction(direction), .motor_enable(motor_enable),
        .angle_setpoint(angle_setpoint), .crank_angle(crank_angle), .at_target(at_target)
    );

    // register copy
    logic [7:0]  r_target;
    logic [15:0] r_kp, r_kd, r_ki, r_kff;
    logic [12:0] r_limit;
    logic [8:0]  r_smooth;
    logic [7:0]  r_tol;
    // loop state copy
    bit primed, motor_on, hold_dir;
    longint filt_pos, last_vel, setp, ffwd, zero_ang, wrap_ang, hold_duty;

    ctl_out_t expected_outputs[$];
    int error_count;
    longint cycle_count;
    bit quiet;
    bit stall_rx;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cascaded_ball_balance_controller_top: mismatch");
            $finish;
        end
    end

    function automatic longint floor_div(longint x, int sh);
        return x >>> sh;
    endfunction

    function automatic longint target_q8();
        longint t;
        t = longint'($signed(r_target));
        if (t < -125) t = -125;
        if (t > 125) t = 125;
        return t * 256;
    endfunction

    task automatic reset_model();
        r_target = 0; r_kp = 256; r_kd = 64; r_limit = 1024; r_ki = 256;
        r_kff = 0; r_smooth = 256; r_tol = 5;
        primed = 0; motor_on = 0; hold_dir = 0;
        filt_pos = 0; last_vel = 0; setp = 0; ffwd = 0;
        zero_ang = 0; wrap_ang = 0; hold_duty = 0;
    endtask

    task automatic report(string what, longint got, longint want);
        $display("ERROR %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Advance the predicted controller by one item and return its outputs.
    function automatic ctl_out_t predict_controller(logic [1:0] f, logic signed [12:0] p,
            logic signed [15:0] v, logic seen, logic signed [15:0] acc,
            logic [13:0] enc, logic idx);
        ctl_out_t o;
        longint pos, s, err, cmd, lim, ff, val, e;
        case (func_t'(f))
            FN_OUTER:
            begin
                pos = longint'(p) * 16;
                s = (r_smooth > 256) ? 256 : longint'(r_smooth);
                if (!primed)
                begin
                    filt_pos = pos;
                    primed = 1;
                end
                else
                    filt_pos = filt_pos + floor_div(s * (pos - filt_pos), 8);
                last_vel = longint'(v);
                if (seen)
                begin
                    motor_on = 1;
                    err = target_q8() - filt_pos;
                    cmd = floor_div(err * longint'(r_kp)
                                    - longint'(v) * 16 * longint'(r_kd), 16);
                    lim = longint'(r_limit);
                    if (cmd > lim) cmd = lim;
                    if (cmd < -lim) cmd = -lim;
                    setp = cmd;
                    ff = floor_div(longint'(acc) * longint'($signed(r_kff)), 8);
                    if (ff > 65535) ff = 65535;
                    if (ff < -65536) ff = -65536;
                    ffwd = ff;
                end
            end
            FN_INNER:
            begin
                if (motor_on)
                begin
                    wrap_ang = longint'($signed(14'(longint'(enc) - zero_ang)));
                    val = longint'(r_ki) * (setp - wrap_ang) + ffwd * 256;
                    lim = longint'(DUTY_LIM) * 256;
                    if (val > lim) val = lim;
                    if (val < -lim) val = -lim;
                    hold_dir = (val >= 0);
                    hold_duty = ((val < 0) ? -val : val) >>> 8;
                    if (idx) zero_ang = longint'(enc);
                end
            end
            FN_STOP:
            begin
                hold_duty = 0; hold_dir = 0; motor_on = 0; ffwd = 0;
            end
            default:
            begin
                zero_ang = longint'(enc);
                primed = 0; filt_pos = 0; last_vel = 0; setp = 0; wrap_ang = 0;
                ffwd = 0; motor_on = 0; hold_duty = 0; hold_dir = 0;
            end
        endcase
        e = target_q8() - filt_pos;
        if (e < 0) e = -e;
        o.duty = 11'(hold_duty);
        o.dir = hold_dir;
        o.en = motor_on;
        o.setp = 14'(setp);
        o.crank = 14'(wrap_ang);
        o.at_tgt = (e <= longint'(r_tol) * 256);
        return o;
    endfunction

    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    // Drive one beat and hold it until accepted; the caller or the next beat drops valid.
    task automatic send_item(logic [1:0] f, logic signed [12:0] p, logic signed [15:0] v,
            logic seen, logic signed [15:0] acc, logic [13:0] enc, logic idx);
        idle_burst();
        in_valid <= 1'b1;
        func <= f; ball_position <= p; ball_velocity <= v; ball_seen <= seen;
        carriage_accel <= acc; encoder_angle <= enc; index_seen <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_outputs.push_back(predict_controller(f, p, v, seen, acc, enc, idx));
        @(negedge clk);
    endtask

    task automatic send_random(int weight_outer);
        int r;
        logic [1:0] f;
        r = $urandom_range(0, 99);
        if (r < weight_outer) f = FN_OUTER;
        else if (r < 90) f = FN_INNER;
        else if (r < 96) f = FN_STOP;
        else f = FN_ZERO;
        send_item(f, 13'($urandom), 16'($urandom), $urandom_range(0, 4) != 0,
                  16'($urandom), 14'($urandom), $urandom_range(0, 7) == 0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        case (idx)
            REG_TARGET: r_target = val[7:0];
            REG_KP:     r_kp = val;
            REG_KD:     r_kd = val;
            REG_LIMIT:  r_limit = val[12:0];
            REG_KI:     r_ki = val;
            REG_KFF:    r_kff = val;
            REG_SMOOTH: r_smooth = val[8:0];
            default:    r_tol = val[7:0];
        endcase
        @(negedge clk);
    endtask

    // Drop the write enable after a run of register writes.
    task automatic end_writes();
        cfg_we <= 1'b0;
    endtask

    // Check each result beat against the oldest prediction.
    always @(posedge clk)
    begin
        ctl_out_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                report("unexpected result beat", 1, 0);
            end
            else
            begin
                w = expected_outputs.pop_front();
                if (pwm_duty !== w.duty) report("pwm_duty", pwm_duty, w.duty);
                if (direction !== w.dir) report("direction", direction, w.dir);
                if (motor_enable !== w.en) report("motor_enable", motor_enable, w.en);
                if (angle_setpoint !== w.setp)
                    report("angle_setpoint", angle_setpoint, $signed(w.setp));
                if (crank_angle !== w.crank)
                    report("crank_angle", crank_angle, $signed(w.crank));
                if (at_target !== w.at_tgt) report("at_target", at_target, w.at_tgt);
            end
        end
    end

    // Receiver stalls in bursts.
    always @(negedge clk)
    begin
        if (quiet)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 5) == 0)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 2) == 0)
            out_ready <= 1'b1;
    end

    task automatic test_directed();
        send_item(FN_INNER, 0, 0, 0, 0, 14'd100, 1);      // motor off: no change
        send_item(FN_OUTER, 13'sd4095, 16'sd32767, 0, 0, 0, 0);  // unseen, first sample raw
        send_item(FN_OUTER, -13'sd4096, -16'sd32768, 1, 16'sd32767, 0, 0);
        send_item(FN_INNER, 0, 0, 0, 0, 14'd8192, 0);    // exact half turn
        send_item(FN_INNER, 0, 0, 0, 0, 14'd16383, 1);   // index re-zero
        send_item(FN_INNER, 0, 0, 0, 0, 14'd0, 0);
        send_item(FN_OUTER, 13'sd4095, 16'sd32767, 1, -16'sd32768, 0, 0);
        send_item(FN_INNER, 0, 0, 0, 0, 14'd5, 0);
        send_item(FN_STOP, 0, 0, 0, 0, 0, 0);
        send_item(FN_INNER, 0, 0, 0, 0, 14'd77, 0);
        send_item(FN_ZERO, 0, 0, 0, 0, 14'd16383, 0);
        send_item(FN_OUTER, 13'sd0, 16'sd0, 1, 16'sd0, 0, 0);
        send_item(FN_INNER, 0, 0, 0, 0, 14'd0, 0);
        send_item(FN_ZERO, 0, 0, 0, 0, 14'd0, 0);
        drain();
    endtask

    task automatic test_extreme_config();
        write_reg(REG_TARGET, 16'h0080);      // -128, saturates to -125
        write_reg(REG_KP, 16'hFFFF);
        write_reg(REG_KD, 16'hFFFF);
        write_reg(REG_LIMIT, 16'h1FFF);
        write_reg(REG_KI, 16'hFFFF);
        write_reg(REG_KFF, 16'h8000);
        write_reg(REG_SMOOTH, 16'h01FF);      // above one acts as one
        write_reg(REG_TOL, 16'h00FF);
        end_writes();
        repeat (150) send_random(40);
        drain();
        write_reg(REG_TARGET, 16'h007F);
        write_reg(REG_KP, 16'h0000);
        write_reg(REG_KD, 16'h0000);
        write_reg(REG_LIMIT, 16'h0000);
        write_reg(REG_KI, 16'h0000);
        write_reg(REG_KFF, 16'h7FFF);
        write_reg(REG_SMOOTH, 16'h0000);
        write_reg(REG_TOL, 16'h0000);
        end_writes();
        repeat (100) send_random(40);
        drain();
    endtask

    task automatic test_random_config();
        repeat (4)
        begin
            write_reg(REG_TARGET, 16'($urandom));
            write_reg(REG_KP, 16'($urandom_range(0, 2048)));
            write_reg(REG_KD, 16'($urandom_range(0, 512)));
            write_reg(REG_LIMIT, 16'($urandom_range(0, 8191)));
            write_reg(REG_KI, 16'($urandom_range(0, 4096)));
            write_reg(REG_KFF, 16'($urandom));
            write_reg(REG_SMOOTH, 16'($urandom_range(0, 300)));
            write_reg(REG_TOL, 16'($urandom_range(0, 255)));
            end_writes();
            repeat (100) send_random(45);
            drain();
        end
    endtask

    task automatic test_quiet_run();
        quiet = 1;
        repeat (150) send_random(45);
        drain();
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        quiet = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_TARGET; cfg_data = 16'd0;
        in_valid = 1'b0; out_ready = 1'b0;
        func = FN_OUTER; ball_position = 0; ball_velocity = 0; ball_seen = 0;
        carriage_accel = 0; encoder_angle = 0; index_seen = 0;
        reset_model();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_extreme_config();
        test_random_config();
        test_quiet_run();
        if (error_count == 0)
            $display("cascaded_ball_balance_controller_top: match");
        else
            $display("cascaded_ball_balance_controller_top: mismatch");
        $finish;
    end

endmodule

>>> sim.f
sv/cbb_pkg.sv
sv/cbb_mul.sv
sv/cascaded_ball_balance_controller_top.sv
test/cascaded_ball_balance_controller_top_test.sv
